FILE: hdl/assert_macros.svh
// Assertion macros included by the top-level compensation module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

FILE: hdl/bsc_pkg.sv
// Shared types, constants and helper functions of the compensation pipeline.
package bsc_pkg;

  localparam int DIV_STAGES = 32;

  localparam logic [2:0] CFG_OSS      = 3'd0;
  localparam logic [2:0] CFG_AC1_AC3  = 3'd1;
  localparam logic [2:0] CFG_AC4_B2   = 3'd2;
  localparam logic [2:0] CFG_AC5_AC6  = 3'd3;
  localparam logic [2:0] CFG_MC_MD    = 3'd4;

  typedef struct packed {
    logic [1:0]  oss;
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] mc;
    logic [31:0] md;
  } coeff_t;

  // Sideband carried alongside the temperature divider.
  typedef struct packed {
    logic        valid;
    logic        fault;
    logic        neg;
    logic [31:0] x1;
    logic [18:0] up;
  } div1_sb_t;

  // Sideband carried alongside the pressure divider.
  typedef struct packed {
    logic        valid;
    logic        fault;
    logic        twice;
    logic [31:0] temp;
  } div2_sb_t;

  typedef struct packed {
    logic        valid;
    logic        fault;
    logic [31:0] temp;
    logic [18:0] up;
  } track_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    logic signed [31:0] s;
    s = $signed(v) >>> n;
    return $unsigned(s);
  endfunction

  function automatic logic [31:0] oss_scale(input logic [1:0] oss);
    logic [31:0] r;
    case (oss)
      2'd0:    r = 32'd50000;
      2'd1:    r = 32'd25000;
      2'd2:    r = 32'd12500;
      default: r = 32'd6250;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/bsc_cfg.sv
// Configuration register file with coefficient unpacking.
module bsc_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output bsc_pkg::coeff_t     coeff
);

  logic [1:0]  oss;
  logic [47:0] reg_ac1_ac3;
  logic [47:0] reg_ac4_b2;
  logic [31:0] reg_ac5_ac6;
  logic [31:0] reg_mc_md;

  always_ff @(posedge clk) begin
    if (rst) begin
      oss         <= 2'd1;
      reg_ac1_ac3 <= '0;
      reg_ac4_b2  <= '0;
      reg_ac5_ac6 <= '0;
      reg_mc_md   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bsc_pkg::CFG_OSS:     oss         <= cfg_data[1:0];
        bsc_pkg::CFG_AC1_AC3: reg_ac1_ac3 <= cfg_data;
        bsc_pkg::CFG_AC4_B2:  reg_ac4_b2  <= cfg_data;
        bsc_pkg::CFG_AC5_AC6: reg_ac5_ac6 <= cfg_data[31:0];
        bsc_pkg::CFG_MC_MD:   reg_mc_md   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coeff.oss = oss;
    coeff.ac1 = {{16{reg_ac1_ac3[47]}}, reg_ac1_ac3[47:32]};
    coeff.ac2 = {{16{reg_ac1_ac3[31]}}, reg_ac1_ac3[31:16]};
    coeff.ac3 = {{16{reg_ac1_ac3[15]}}, reg_ac1_ac3[15:0]};
    coeff.ac4 = {16'd0, reg_ac4_b2[47:32]};
    coeff.b1  = {{16{reg_ac4_b2[31]}}, reg_ac4_b2[31:16]};
    coeff.b2  = {{16{reg_ac4_b2[15]}}, reg_ac4_b2[15:0]};
    coeff.ac5 = {16'd0, reg_ac5_ac6[31:16]};
    coeff.ac6 = {16'd0, reg_ac5_ac6[15:0]};
    coeff.mc  = {{16{reg_mc_md[31]}}, reg_mc_md[31:16]};
    coeff.md  = {{16{reg_mc_md[15]}}, reg_mc_md[15:0]};
  end

endmodule

FILE: hdl/bsc_udiv.sv
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
module bsc_udiv (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  logic [31:0] rem_s [bsc_pkg::DIV_STAGES];
  logic [31:0] num_s [bsc_pkg::DIV_STAGES];
  logic [31:0] den_s [bsc_pkg::DIV_STAGES];
  logic [31:0] quo_s [bsc_pkg::DIV_STAGES];

  for (genvar i = 0; i < bsc_pkg::DIV_STAGES; i++) begin : g_stage
    logic [31:0] r_in, n_in, d_in, q_in;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        take;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_s[i-1];
      assign n_in = num_s[i-1];
      assign d_in = den_s[i-1];
      assign q_in = quo_s[i-1];
    end

    assign trial = {r_in, n_in[31]};
    assign diff  = trial - {1'b0, d_in};
    assign take  = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i] <= take ? diff[31:0] : trial[31:0];
        num_s[i] <= {n_in[30:0], 1'b0};
        den_s[i] <= d_in;
        quo_s[i] <= {q_in[30:0], take};
      end
    end
  end

  assign quo = quo_s[bsc_pkg::DIV_STAGES-1];

endmodule

FILE: hdl/baro_sensor_compensation.sv
// The data path has 80 register stages from input to result word.
// Throughput: one word per cycle unless the output stalls.
// The two 32-stage dividers set the depth.
// A stall at the output freezes the whole pipeline and stalls the input.
// Reset (synchronous) clears all valid bits, sets oversampling to 1 and
// clears the coefficient registers.
module baro_sensor_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        raw_temperature,
  input  logic [18:0]        raw_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] temperature_tenths,
  output logic signed [31:0] pressure_pa,
  output logic               divide_fault
);
  `include "assert_macros.svh"

  bsc_pkg::coeff_t c;
  logic adv;

  bsc_cfg u_cfg (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .coeff(c)
  );

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input register and first multiply.
  logic        v0, vA, vB;
  logic [15:0] ut0;
  logic [18:0] up0, upA, upB;
  logic [31:0] prodA, x1B, denB;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      vA <= 1'b0;
      vB <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      vA <= v0;
      vB <= vA;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ut0   <= raw_temperature;
      up0   <= raw_pressure;
      prodA <= ({16'd0, ut0} - c.ac6) * c.ac5;
      upA   <= up0;
      x1B   <= bsc_pkg::asr(prodA, 5'd15);
      denB  <= bsc_pkg::asr(prodA, 5'd15) + c.md;
      upB   <= upA;
    end
  end

  // Signed temperature division via magnitudes.
  logic [31:0] numT, numT_abs, denT_abs, q1;
  bsc_pkg::div1_sb_t sb1_in;
  bsc_pkg::div1_sb_t sb1 [bsc_pkg::DIV_STAGES];

  assign numT     = c.mc << 11;
  assign numT_abs = numT[31] ? (32'd0 - numT) : numT;
  assign denT_abs = denB[31] ? (32'd0 - denB) : denB;

  always_comb begin
    sb1_in.valid = vB;
    sb1_in.fault = (denB == 32'd0);
    sb1_in.neg   = numT[31] ^ denB[31];
    sb1_in.x1    = x1B;
    sb1_in.up    = upB;
  end

  bsc_udiv u_div_temp (.clk, .en(adv), .num(numT_abs), .den(denT_abs), .quo(q1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bsc_pkg::DIV_STAGES; i++) sb1[i] <= '0;
    end else if (adv) begin
      sb1[0] <= sb1_in;
      for (int i = 1; i < bsc_pkg::DIV_STAGES; i++) sb1[i] <= sb1[i-1];
    end
  end

  // Post-division pressure coefficient chain.
  bsc_pkg::track_t trkD, trkP1, trkP2, trkP3, trkP4, trkP5, trkP6, trkP7, trkP8;
  bsc_pkg::div1_sb_t s1;
  logic [31:0] x2T, b5D, b6P1, sqp, a2p, a3p, sq, x2a, x1b, x2aP4, x1bP4;
  logic [31:0] b2sq, b1sq, x3, x3b, b3, x3s, b4p, dif, b4, b7;

  assign s1  = sb1[bsc_pkg::DIV_STAGES-1];
  assign x2T = s1.neg ? (32'd0 - q1) : q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trkD  <= '0;
      trkP1 <= '0;
      trkP2 <= '0;
      trkP3 <= '0;
      trkP4 <= '0;
      trkP5 <= '0;
      trkP6 <= '0;
      trkP7 <= '0;
      trkP8 <= '0;
    end else if (adv) begin
      trkD  <= '{valid: s1.valid, fault: s1.fault, temp: 32'd0, up: s1.up};
      trkP1 <= '{valid: trkD.valid, fault: trkD.fault,
                 temp: bsc_pkg::asr(b5D + 32'd8, 5'd4), up: trkD.up};
      trkP2 <= trkP1;
      trkP3 <= trkP2;
      trkP4 <= trkP3;
      trkP5 <= trkP4;
      trkP6 <= trkP5;
      trkP7 <= trkP6;
      trkP8 <= trkP7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b5D   <= s1.x1 + x2T;
      b6P1  <= b5D - 32'd4000;
      sqp   <= b6P1 * b6P1;
      a2p   <= c.ac2 * b6P1;
      a3p   <= c.ac3 * b6P1;
      sq    <= bsc_pkg::asr(sqp, 5'd12);
      x2a   <= bsc_pkg::asr(a2p, 5'd11);
      x1b   <= bsc_pkg::asr(a3p, 5'd13);
      b2sq  <= c.b2 * sq;
      b1sq  <= c.b1 * sq;
      x2aP4 <= x2a;
      x1bP4 <= x1b;
      x3    <= bsc_pkg::asr(b2sq, 5'd11) + x2aP4;
      x3b   <= bsc_pkg::asr(x1bP4 + bsc_pkg::asr(b1sq, 5'd16) + 32'd2, 5'd2);
      b3    <= bsc_pkg::asr((((c.ac1 << 2) + x3) << c.oss) + 32'd2, 5'd2);
      x3s   <= x3b + 32'd32768;
      b4p   <= c.ac4 * x3s;
      dif   <= {13'd0, trkP6.up} - b3;
      b4    <= {15'd0, b4p[31:15]};
      b7    <= dif * bsc_pkg::oss_scale(c.oss);
    end
  end

  // Unsigned pressure division. The model doubles before dividing when b7
  // has a clear top bit and after dividing otherwise.
  logic [31:0] num2, q2;
  bsc_pkg::div2_sb_t sb2_in;
  bsc_pkg::div2_sb_t sb2 [bsc_pkg::DIV_STAGES];

  assign num2 = b7[31] ? b7 : {b7[30:0], 1'b0};

  always_comb begin
    sb2_in.valid = trkP8.valid;
    sb2_in.fault = trkP8.fault || (b4 == 32'd0);
    sb2_in.twice = b7[31];
    sb2_in.temp  = trkP8.temp;
  end

  bsc_udiv u_div_pres (.clk, .en(adv), .num(num2), .den(b4), .quo(q2));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bsc_pkg::DIV_STAGES; i++) sb2[i] <= '0;
    end else if (adv) begin
      sb2[0] <= sb2_in;
      for (int i = 1; i < bsc_pkg::DIV_STAGES; i++) sb2[i] <= sb2[i-1];
    end
  end

  // Final pressure correction.
  bsc_pkg::div2_sb_t s2, sQ0, sQ1, sQ2;
  logic [31:0] pQ0, pQ1, pQ2, m1, m2, m3, x2q, x1q, p_fin;

  assign s2    = sb2[bsc_pkg::DIV_STAGES-1];
  assign x1q   = bsc_pkg::asr(m3, 5'd16);
  assign p_fin = pQ2 + bsc_pkg::asr(x1q + x2q + 32'd3791, 5'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      sQ0       <= '0;
      sQ1       <= '0;
      sQ2       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sQ0       <= s2;
      sQ1       <= sQ0;
      sQ2       <= sQ1;
      out_valid <= sQ2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pQ0 <= s2.twice ? {q2[30:0], 1'b0} : q2;
      m1  <= bsc_pkg::asr(pQ0, 5'd8) * bsc_pkg::asr(pQ0, 5'd8);
      m2  <= 32'd7357 * pQ0;
      pQ1 <= pQ0;
      m3  <= m1 * 32'd3038;
      x2q <= bsc_pkg::asr(32'd0 - m2, 5'd16);
      pQ2 <= pQ1;
      temperature_tenths <= sQ2.fault ? 32'sd0 : $signed(sQ2.temp);
      pressure_pa        <= sQ2.fault ? 32'sd0 : $signed(p_fin);
      divide_fault       <= sQ2.fault;
    end
  end

  `ASSERT_IMPL(a_fault_zero, out_valid && divide_fault,
               temperature_tenths == 32'sd0 && pressure_pa == 32'sd0)
  `ASSERT_NEXT(a_hold_out, in_stall, $stable(pressure_pa) && $stable(out_valid))
  `ASSERT_NEXT(a_hold_mid, !adv, $stable(trkP3) && $stable(sQ1))

endmodule
